// ===== design/slist_pkg.sv =====
`timescale 1ns / 1ps
// Package for the sorted list block: request/response structs, status codes,
// cell command struct and default capacity. No dependencies.
package slist_pkg;

    // Default number of cells in the row
    localparam int unsigned CAPACITY_DEF = 16;

    // Field widths fixed by the interface
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 5;

    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_REMOVE = 1'b1
    } t_req_type;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_REMOVED   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        t_req_type                  req_type;
        logic signed [VALUE_W-1:0]  value;
    } t_req;

    typedef struct packed {
        t_status                    status;
        logic [COUNT_W-1:0]         entry_count;
        logic signed [VALUE_W-1:0]  min_value;
        logic signed [VALUE_W-1:0]  max_value;
    } t_rsp;

    // Command broadcast to every cell of the row
    typedef struct packed {
        logic                       ins_en;
        logic                       rem_en;
        logic signed [VALUE_W-1:0]  value;
    } t_cell_cmd;

endpackage

// ===== design/slist_cell.sv =====
`timescale 1ns / 1ps
// One cell of the sorted row: holds one value and its valid bit, compares
// against the broadcast command and shifts with its neighbors. Uses slist_pkg.
module slist_cell (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  slist_pkg::t_cell_cmd                  i_cmd,
    input  logic                                  i_left_after,
    input  logic signed [slist_pkg::VALUE_W-1:0]  i_left_value,
    input  logic                                  i_left_valid,
    input  logic signed [slist_pkg::VALUE_W-1:0]  i_right_value,
    input  logic                                  i_right_valid,
    input  logic                                  i_found,
    output logic                                  o_after,
    output logic                                  o_match,
    output logic signed [slist_pkg::VALUE_W-1:0]  o_value,
    output logic                                  o_valid,
    output logic signed [slist_pkg::VALUE_W-1:0]  o_next_value,
    output logic                                  o_next_valid
);

    logic signed [slist_pkg::VALUE_W-1:0] r_value;
    logic signed [slist_pkg::VALUE_W-1:0] n_value;
    logic                                 r_valid;
    logic                                 n_valid;
    logic                                 ge;

    // Compare held value against the request value
    always_comb begin
        o_after = !r_valid || (r_value > i_cmd.value);
        ge      = r_valid && (r_value >= i_cmd.value);
        o_match = r_valid && (r_value == i_cmd.value);
    end

    // Shift right on insert, shift left on remove, otherwise hold
    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_cmd.ins_en) begin
            if (i_left_after) begin
                n_value = i_left_value;
                n_valid = i_left_valid;
            end else if (o_after) begin
                n_value = i_cmd.value;
                n_valid = 1'b1;
            end
        end else if (i_cmd.rem_en && i_found && ge) begin
            n_value = i_right_value;
            n_valid = i_right_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value      = r_value;
    assign o_valid      = r_valid;
    assign o_next_value = n_value;
    assign o_next_valid = n_valid;

endmodule

// ===== design/sorted_list_insert_remove_top.sv =====
`timescale 1ns / 1ps
// Top level of the sorted list: row of slist_cell instances, entry counter and
// registered response stage. Uses slist_pkg and slist_cell.
//
// Keeps up to CAPACITY signed values in ascending order in a row of cells.
// Every request is compared against all cells at once and the row shifts in
// the same cycle, so one request is accepted per clock while o_stall is low,
// and its response is registered on acceptance. The response register is
// the only buffer: o_stall rises while a response waits and i_stall is high.
// Throughput is one request per cycle while o_stall is low; the combinational
// compare across the cell row and the min/max selection set the clock period.
module sorted_list_insert_remove_top #(
    parameter int unsigned CAPACITY = slist_pkg::CAPACITY_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  slist_pkg::t_req i_req,
    output logic            o_valid,
    input  logic            i_stall,
    output slist_pkg::t_rsp o_rsp
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned VW    = slist_pkg::VALUE_W;

    logic                     accept;
    logic                     full;
    logic                     found;
    slist_pkg::t_cell_cmd     cmd;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic                     r_out_valid;
    slist_pkg::t_rsp          r_rsp;
    slist_pkg::t_rsp          n_rsp;
    logic [CNT_W+4:0]         count_ext;
    logic signed [VW-1:0]     max_sel;

    logic                     after   [CAPACITY];
    logic                     match   [CAPACITY];
    logic signed [VW-1:0]     value   [CAPACITY];
    logic                     valid   [CAPACITY];
    logic signed [VW-1:0]     nvalue  [CAPACITY];
    logic                     nvalid  [CAPACITY];
    logic [CAPACITY-1:0]      match_vec;

    // Handshake: accept when the response slot is free or being drained
    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;
    assign full    = valid[CAPACITY-1];

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            match_vec[i] = match[i];
        end
        found = |match_vec;
    end

    // Broadcast command to the row
    always_comb begin
        cmd.ins_en = accept && (i_req.req_type == slist_pkg::REQ_INSERT) && !full;
        cmd.rem_en = accept && (i_req.req_type == slist_pkg::REQ_REMOVE);
        cmd.value  = i_req.value;
    end

    // Build the cell row
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                 left_after;
        logic signed [VW-1:0] left_value;
        logic                 left_valid;
        logic signed [VW-1:0] right_value;
        logic                 right_valid;

        if (g == 0) begin : g_first
            assign left_after = 1'b0;
            assign left_value = '0;
            assign left_valid = 1'b0;
        end else begin : g_mid
            assign left_after = after[g-1];
            assign left_value = value[g-1];
            assign left_valid = valid[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_value = '0;
            assign right_valid = 1'b0;
        end else begin : g_inner
            assign right_value = value[g+1];
            assign right_valid = valid[g+1];
        end

        slist_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (cmd),
            .i_left_after  (left_after),
            .i_left_value  (left_value),
            .i_left_valid  (left_valid),
            .i_right_value (right_value),
            .i_right_valid (right_valid),
            .i_found       (found),
            .o_after       (after[g]),
            .o_match       (match[g]),
            .o_value       (value[g]),
            .o_valid       (valid[g]),
            .o_next_value  (nvalue[g]),
            .o_next_valid  (nvalid[g])
        );
    end

    // Track the entry count
    always_comb begin
        n_count = r_count;
        if (cmd.ins_en) begin
            n_count = r_count + CNT_W'(1);
        end else if (cmd.rem_en && found) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Select the last valid cell of the updated row as the maximum
    always_comb begin
        max_sel = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (nvalid[i] && ((i == CAPACITY - 1) || !nvalid[(i + 1) % CAPACITY])) begin
                max_sel = max_sel | nvalue[i];
            end
        end
    end

    // Form the response
    always_comb begin
        count_ext         = {5'b0, n_count};
        n_rsp.entry_count = count_ext[4:0];
        n_rsp.min_value   = nvalid[0] ? nvalue[0] : '0;
        n_rsp.max_value   = max_sel;
        if (i_req.req_type == slist_pkg::REQ_INSERT) begin
            n_rsp.status = full ? slist_pkg::ST_FULL : slist_pkg::ST_INSERTED;
        end else begin
            n_rsp.status = found ? slist_pkg::ST_REMOVED : slist_pkg::ST_NOT_FOUND;
        end
    end

    // Hold the response until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_rsp;

endmodule

// ===== design/slist_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the sorted list top level, bound to it below.
// Uses slist_pkg and sorted_list_insert_remove_top.
module slist_checker #(
    parameter int unsigned CAPACITY = slist_pkg::CAPACITY_DEF
) (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_valid,
    input logic            o_stall,
    input logic            o_valid,
    input logic            i_stall,
    input slist_pkg::t_rsp o_rsp
);

    localparam logic [31:0] CAP_W = 32'(CAPACITY);

    // Every accepted request yields a response on the next cycle
    a_resp_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_valid)
        else $error("no response after accepted request");

    // A stalled response holds
    a_resp_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_rsp))
        else $error("stalled response changed");

    // Empty list reports zero bounds
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_rsp.entry_count == 5'd0) && (CAPACITY < 32)
        |-> (o_rsp.min_value == 0) && (o_rsp.max_value == 0))
        else $error("empty list with nonzero bounds");

    // Reported minimum never exceeds the reported maximum
    a_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_rsp.min_value <= o_rsp.max_value)
        else $error("minimum above maximum");

    // A dropped insert only happens at full capacity
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_rsp.status == slist_pkg::ST_FULL)
        |-> o_rsp.entry_count == CAP_W[4:0])
        else $error("full status below capacity");

endmodule

bind sorted_list_insert_remove_top slist_checker #(
    .CAPACITY (CAPACITY)
) u_slist_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_rsp   (o_rsp)
);
